// File: design/lpht_pkg.sv
// Shared types and constants of the linear probing hash table.
package lpht_pkg;

    localparam int KEY_W           = 64;
    localparam int NAME_W          = 64;
    localparam int KIND_W          = 32;
    localparam int SLOT_W          = 6;
    localparam int STATUS_W        = 2;
    localparam int OP_W            = 2;
    localparam int TSIZE_W         = 7;
    localparam logic [TSIZE_W-1:0] TSIZE_RST = 7'd64;
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_KEY_BYTES   = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [KIND_W-1:0] kind;
    } t_entry;

endpackage

// File: design/lpht_ifs.sv
// Request and response channel interfaces.
interface lpht_req_if
    import lpht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  new_key;
    logic [NAME_W-1:0] name_in;
    logic [KIND_W-1:0] kind_in;

    modport source (output valid, opcode, key, new_key, name_in, kind_in, input ready);
    modport sink   (input valid, opcode, key, new_key, name_in, kind_in, output ready);
endinterface

interface lpht_rsp_if
    import lpht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    found_key;
    logic [NAME_W-1:0]   found_name;
    logic [KIND_W-1:0]   found_kind;

    modport source (output valid, status, slot, found_key, found_name, found_kind,
                    input ready);
    modport sink   (input valid, status, slot, found_key, found_name, found_kind,
                    output ready);
endinterface

// File: design/lpht_hash.sv
// Home slot unit: byte sum of the key, reduced modulo the table size one bit per cycle.
module lpht_hash
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [KEY_W-1:0]                 i_key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_size,
    output logic                             o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_home
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int SW   = $clog2(TABLE_DEPTH + 1);
    localparam int SUMW = $clog2(KEY_BYTES * 255 + 1);
    localparam int CNTW = $clog2(SUMW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [SUMW-1:0] r_sum, n_sum;
    logic [SW-1:0]   r_rem, n_rem;
    logic [SW-1:0]   r_size, n_size;
    logic [SUMW-1:0] w_sum;
    logic [SW:0]     w_rem2;
    logic [SW:0]     w_diff;

    always_comb begin
        w_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_sum = w_sum + SUMW'(i_key[8*b +: 8]);
        end
    end

    // restoring remainder step
    assign w_rem2 = {r_rem, r_sum[SUMW-1]};
    assign w_diff = w_rem2 - {1'b0, r_size};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_rem  = r_rem;
        n_size = r_size;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(SUMW);
            n_sum  = w_sum;
            n_rem  = '0;
            n_size = i_size;
        end else if (r_busy) begin
            n_rem = (w_rem2 >= {1'b0, r_size}) ? w_diff[SW-1:0] : w_rem2[SW-1:0];
            n_sum = r_sum << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_sum  <= n_sum;
        r_rem  <= n_rem;
        r_size <= n_size;
    end

    assign o_done = r_done;
    assign o_home = r_rem[AW-1:0];

endmodule

// File: design/linear_probe_hash_table_unit.sv
// Top level: hash table with slot memories, probe sequencer and result register.
// The home slot takes one remainder bit per cycle over the byte sum width SUMW (11 at eight
// key bytes), then one slot memory read per probe. One item in work at a time, the next
// taken while a result waits.
// After reset a pass writes every slot mark to empty, no item taken.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TSIZE_W-1:0] i_cfg_data,
    lpht_req_if.sink           i_req,
    lpht_rsp_if.source         o_rsp
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int SW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (SW > TSIZE_W) ? SW : TSIZE_W;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [TSIZE_W-1:0]  r_table_size, n_table_size;
    t_op                 r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_new_key, n_new_key;
    logic [NAME_W-1:0]   r_name, n_name;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [SW-1:0]       r_size, n_size;
    logic [AW-1:0]       r_pos, n_pos;
    logic [SW-1:0]       r_iss_cnt, n_iss_cnt;
    logic [SW-1:0]       r_chk_cnt, n_chk_cnt;
    logic                r_rd_vld, n_rd_vld;
    logic [AW-1:0]       r_rd_pos, n_rd_pos;
    t_status             r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    t_entry              r_res_found, n_res_found;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    t_entry              r_out_found, n_out_found;

    logic [1:0]          mark_mem [TABLE_DEPTH];
    t_entry              data_mem [TABLE_DEPTH];
    logic [1:0]          r_mark_q;
    t_entry              r_data_q;

    logic                w_mark_we;
    logic [AW-1:0]       w_mark_wa;
    logic [1:0]          w_mark_wd;
    logic                w_data_we;
    t_entry              w_data_wd;

    logic                w_hash_start;
    logic                w_home_vld;
    logic [AW-1:0]       w_home;
    logic [CMPW-1:0]     w_ts_ext;
    logic [SW-1:0]       w_eff_size;
    logic [SW-1:0]       w_pos_inc;
    logic [SW-1:0]       w_chk_nxt;
    logic                w_match;
    logic [AW+SLOT_W-1:0] w_slot_ext;

    lpht_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (i_req.key),
        .i_size  (w_eff_size),
        .o_done  (w_home_vld),
        .o_home  (w_home)
    );

    // size zero acts as one, sizes above the depth saturate
    assign w_ts_ext   = CMPW'(r_table_size);
    assign w_eff_size = (r_table_size == '0)                ? SW'(1) :
                        (w_ts_ext > CMPW'(TABLE_DEPTH))     ? SW'(TABLE_DEPTH) :
                                                              SW'(r_table_size);

    assign w_pos_inc  = SW'(r_pos) + 1'b1;
    assign w_chk_nxt  = r_chk_cnt + 1'b1;
    assign w_slot_ext = {{SLOT_W{1'b0}}, r_rd_pos};
    assign w_match    = (r_op == OP_INSERT) ? (r_mark_q != MARK_USED) :
                        ((r_mark_q == MARK_USED) && (r_data_q.key == r_key));

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_table_size = r_table_size;
        n_op         = r_op;
        n_key        = r_key;
        n_new_key    = r_new_key;
        n_name       = r_name;
        n_kind       = r_kind;
        n_size       = r_size;
        n_pos        = r_pos;
        n_iss_cnt    = r_iss_cnt;
        n_chk_cnt    = r_chk_cnt;
        n_rd_vld     = 1'b0;
        n_rd_pos     = r_rd_pos;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_found  = r_res_found;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_found  = r_out_found;
        w_hash_start = 1'b0;
        w_mark_we    = 1'b0;
        w_mark_wa    = r_rd_pos;
        w_mark_wd    = MARK_USED;
        w_data_we    = 1'b0;
        w_data_wd    = '{key: r_key, name: r_name, kind: r_kind};

        if (i_cfg_we) begin
            n_table_size = i_cfg_data;
        end
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_mark_we  = 1'b1;
                w_mark_wa  = r_clr_addr;
                w_mark_wd  = MARK_EMPTY;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op         = t_op'(i_req.opcode);
                    n_key        = i_req.key;
                    n_new_key    = i_req.new_key;
                    n_name       = i_req.name_in;
                    n_kind       = i_req.kind_in;
                    n_size       = w_eff_size;
                    w_hash_start = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                if (w_home_vld) begin
                    n_pos     = w_home;
                    n_iss_cnt = '0;
                    n_chk_cnt = '0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                // reads run one slot ahead of the compare
                if (r_iss_cnt != r_size) begin
                    n_iss_cnt = r_iss_cnt + 1'b1;
                    n_pos     = (w_pos_inc == r_size) ? '0 : w_pos_inc[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_rd_pos  = r_pos;
                end
                if (r_rd_vld) begin
                    if (w_match) begin
                        n_res_status = ST_OK;
                        n_res_slot   = w_slot_ext[SLOT_W-1:0];
                        n_res_found  = '0;
                        case (r_op)
                            OP_INSERT: begin
                                w_mark_we = 1'b1;
                                w_mark_wd = MARK_USED;
                                w_data_we = 1'b1;
                            end
                            OP_SEARCH: begin
                                n_res_found = r_data_q;
                            end
                            OP_UPDATE: begin
                                w_data_we = 1'b1;
                                w_data_wd = '{key: r_new_key, name: r_name, kind: r_kind};
                            end
                            OP_DELETE: begin
                                w_mark_we = 1'b1;
                                w_mark_wd = MARK_DELETED;
                            end
                            default: begin
                            end
                        endcase
                        n_rd_vld = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        n_chk_cnt = w_chk_nxt;
                        if (w_chk_nxt == r_size) begin
                            n_res_status = (r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                            n_res_slot   = '0;
                            n_res_found  = '0;
                            n_rd_vld     = 1'b0;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_found  = r_res_found;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_table_size <= TSIZE_RST;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_table_size <= n_table_size;
            r_rd_vld     <= n_rd_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_new_key    <= n_new_key;
        r_name       <= n_name;
        r_kind       <= n_kind;
        r_size       <= n_size;
        r_pos        <= n_pos;
        r_iss_cnt    <= n_iss_cnt;
        r_chk_cnt    <= n_chk_cnt;
        r_rd_pos     <= n_rd_pos;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_found  <= n_out_found;
    end

    // slot memories, one read per cycle at the probe pointer
    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            mark_mem[w_mark_wa] <= w_mark_wd;
        end
        r_mark_q <= mark_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            data_mem[r_rd_pos] <= w_data_wd;
        end
        r_data_q <= data_mem[r_pos];
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot       = r_out_slot;
    assign o_rsp.found_key  = r_out_found.key;
    assign o_rsp.found_name = r_out_found.name;
    assign o_rsp.found_kind = r_out_found.kind;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (SW'(r_pos) < r_size))
        else $error("probe pointer outside table");

    a_home_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_home_vld && (r_state == S_HASH)) |-> (SW'(w_home) < r_size))
        else $error("home slot outside table");

    a_chk_behind_iss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_chk_cnt <= r_iss_cnt))
        else $error("compare ran ahead of reads");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

endmodule

// File: tb/tb_linear_probe_hash_table_unit.sv
// Testbench for the hash table unit: directed and random ops checked against a shadow table.
module tb_linear_probe_hash_table_unit;
    import lpht_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_PCT       = 13;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 105;
    localparam int CALM_PHASE     = 6;
    localparam int POOL_N         = 16;

    typedef struct {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  new_key;
        logic [NAME_W-1:0] name;
        logic [KIND_W-1:0] kind;
    } t_table_op;

    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [KIND_W-1:0] kind;
    } t_table_rsp;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [TSIZE_W-1:0] cfg_data;

    lpht_req_if req_if ();
    lpht_rsp_if rsp_if ();

    linear_probe_hash_table_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // shadow copy of the table and its size register
    t_mark              shadow_mark [DEF_TABLE_DEPTH];
    logic [KEY_W-1:0]   shadow_key  [DEF_TABLE_DEPTH];
    logic [NAME_W-1:0]  shadow_name [DEF_TABLE_DEPTH];
    logic [KIND_W-1:0]  shadow_kind [DEF_TABLE_DEPTH];
    logic [TSIZE_W-1:0] shadow_size;

    t_table_op          op_queue [$];
    t_table_rsp         rsp_due [$];
    logic [KEY_W-1:0]   key_pool [POOL_N];
    int                 mismatch_count;
    bit                 calm;
    int                 quiet_cycles;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int home_slot(input logic [KEY_W-1:0] key, input int size);
        int sum;
        sum = 0;
        for (int b = 0; b < DEF_KEY_BYTES; b++) sum += int'(key[8*b +: 8]);
        return sum % size;
    endfunction

    // Applies one op to the shadow table and returns the response it must produce.
    function automatic t_table_rsp apply_table_op(input t_table_op it);
        t_table_rsp r;
        int         size;
        int         pos;
        int         hit;
        size = (shadow_size == 0) ? 1 :
               (int'(shadow_size) > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(shadow_size);
        r = '{ST_OK, '0, '0, '0, '0};
        pos = home_slot(it.key, size);
        hit = -1;
        if (it.op == OP_INSERT) begin
            for (int n = 0; n < size && hit < 0; n++) begin
                if (shadow_mark[pos] != MARK_USED) hit = pos;
                else pos = (pos + 1) % size;
            end
            if (hit < 0) begin
                r.status = ST_FULL;
            end else begin
                shadow_mark[hit] = MARK_USED;
                shadow_key[hit]  = it.key;
                shadow_name[hit] = it.name;
                shadow_kind[hit] = it.kind;
                r.slot = SLOT_W'(hit);
            end
        end else begin
            // lookups stop only at a match or after the full probe length; empty slots do not end the search
            for (int n = 0; n < size && hit < 0; n++) begin
                if (shadow_mark[pos] == MARK_USED && shadow_key[pos] == it.key) hit = pos;
                else pos = (pos + 1) % size;
            end
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.slot = SLOT_W'(hit);
                case (it.op)
                    OP_SEARCH: begin
                        r.key  = shadow_key[hit];
                        r.name = shadow_name[hit];
                        r.kind = shadow_kind[hit];
                    end
                    OP_UPDATE: begin
                        shadow_key[hit]  = it.new_key;
                        shadow_name[hit] = it.name;
                        shadow_kind[hit] = it.kind;
                    end
                    default: begin
                        shadow_mark[hit] = MARK_DELETED;
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic t_table_op make_op(input t_op op, input logic [KEY_W-1:0] key,
                                          input logic [KEY_W-1:0] new_key,
                                          input logic [NAME_W-1:0] name,
                                          input logic [KIND_W-1:0] kind);
        t_table_op it;
        it.op      = op;
        it.key     = key;
        it.new_key = new_key;
        it.name    = name;
        it.kind    = kind;
        return it;
    endfunction

    function automatic logic [KEY_W-1:0] rand_word64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly ops on a small pool of colliding keys, some stray keys as noise.
    function automatic t_table_op random_op();
        t_table_op it;
        int        pick;
        pick = $urandom_range(99);
        it.op = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_SEARCH :
                (pick < 75) ? OP_UPDATE : OP_DELETE;
        it.key = ($urandom_range(9) == 0) ? rand_word64() : key_pool[$urandom_range(POOL_N-1)];
        it.new_key = ($urandom_range(4) == 0) ? rand_word64() :
                     key_pool[$urandom_range(POOL_N-1)];
        it.name = rand_word64();
        it.kind = $urandom();
        return it;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                rsp_due.push_back(apply_table_op(make_op(t_op'(req_if.opcode), req_if.key,
                                                         req_if.new_key, req_if.name_in,
                                                         req_if.kind_in)));
            if (!req_if.valid || req_if.ready) begin
                if (op_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    req_if.opcode  <= op_queue[0].op;
                    req_if.key     <= op_queue[0].key;
                    req_if.new_key <= op_queue[0].new_key;
                    req_if.name_in <= op_queue[0].name;
                    req_if.kind_in <= op_queue[0].kind;
                    req_if.valid   <= 1'b1;
                    void'(op_queue.pop_front());
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_table_rsp want;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_due.size() == 0) begin
                    $display("%0t: unexpected item, status %0d slot %0d", $time,
                             rsp_if.status, rsp_if.slot);
                    mismatch_count++;
                end else begin
                    want = rsp_due.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.slot !== want.slot) begin
                        $display("%0t: slot expected %0d got %0d", $time,
                                 want.slot, rsp_if.slot);
                        mismatch_count++;
                    end
                    if (rsp_if.found_key !== want.key) begin
                        $display("%0t: found_key expected %h got %h", $time,
                                 want.key, rsp_if.found_key);
                        mismatch_count++;
                    end
                    if (rsp_if.found_name !== want.name) begin
                        $display("%0t: found_name expected %h got %h", $time,
                                 want.name, rsp_if.found_name);
                        mismatch_count++;
                    end
                    if (rsp_if.found_kind !== want.kind) begin
                        $display("%0t: found_kind expected %h got %h", $time,
                                 want.kind, rsp_if.found_kind);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles in a row with no item moving on either channel
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (op_queue.size() != 0 || req_if.valid || rsp_due.size() != 0) @(negedge clk);
    endtask

    task automatic write_table_size(input logic [TSIZE_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        shadow_size = value;
        @(negedge clk);
    endtask

    initial begin
        logic [KEY_W-1:0]   ones;
        logic [KEY_W-1:0]   base;
        logic [TSIZE_W-1:0] phase_size [NUM_PHASES];
        int                 rot;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.opcode  = '0;
        req_if.key     = '0;
        req_if.new_key = '0;
        req_if.name_in = '0;
        req_if.kind_in = '0;
        rsp_if.ready   = 1'b0;
        calm           = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        shadow_size    = TSIZE_RST;
        for (int i = 0; i < DEF_TABLE_DEPTH; i++) shadow_mark[i] = MARK_EMPTY;
        ones = '1;
        // zero and 127 cover the degenerate and saturating sizes
        phase_size = '{7'd64, 7'd1, 7'd0, 7'd3, 7'd127, 7'd8, 7'd63, 7'd17, 7'd2, 7'd100};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: four slots, keys 0 and all-ones share home slot 0
        write_table_size(7'd4);
        op_queue.push_back(make_op(OP_INSERT, '0, '0, '0, '0));
        op_queue.push_back(make_op(OP_INSERT, ones, '0, ones, '1));
        op_queue.push_back(make_op(OP_SEARCH, ones, '0, '0, '0));
        op_queue.push_back(make_op(OP_SEARCH, 64'd1, '0, '0, '0));
        op_queue.push_back(make_op(OP_INSERT, 64'd1, '0, 64'h4142_4344_4546_4748, 32'h5859_5a00));
        op_queue.push_back(make_op(OP_SEARCH, '0, '0, '0, '0));
        op_queue.push_back(make_op(OP_UPDATE, '0, 64'h8000_0000_0000_0000, ones, '1));
        op_queue.push_back(make_op(OP_SEARCH, '0, '0, '0, '0));
        op_queue.push_back(make_op(OP_SEARCH, 64'h8000_0000_0000_0000, '0, '0, '0));
        op_queue.push_back(make_op(OP_INSERT, 64'd3, '0, 64'h1234, 32'h5678));
        // table now full
        op_queue.push_back(make_op(OP_INSERT, '0, '0, ones, '1));
        op_queue.push_back(make_op(OP_DELETE, ones, '0, '0, '0));
        op_queue.push_back(make_op(OP_SEARCH, ones, '0, '0, '0));
        op_queue.push_back(make_op(OP_DELETE, ones, '0, '0, '0));
        op_queue.push_back(make_op(OP_UPDATE, ones, ones, ones, '1));
        // reuse of the tombstone
        op_queue.push_back(make_op(OP_INSERT, ones, '0, 64'h00ff_00ff_00ff_00ff, 32'hff00_ff00));
        op_queue.push_back(make_op(OP_SEARCH, ones, '0, '0, '0));
        op_queue.push_back(make_op(OP_SEARCH, 64'd7, '0, '0, '0));
        op_queue.push_back(make_op(OP_DELETE, 64'd3, '0, '0, '0));
        op_queue.push_back(make_op(OP_INSERT, 64'd7, '0, ones, '0));
        op_queue.push_back(make_op(OP_SEARCH, 64'd7, '0, '0, '0));

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_table_size(phase_size[p]);
            calm = (p == CALM_PHASE);
            // pairs of keys with equal byte sums, so they collide at any size
            for (int i = 0; i < POOL_N / 2; i++) begin
                base = rand_word64();
                rot = 8 * $urandom_range(1, 7);
                key_pool[2*i]   = base;
                key_pool[2*i+1] = (base << rot) | (base >> (KEY_W - rot));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) op_queue.push_back(random_op());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lpht_pkg.sv
design/lpht_ifs.sv
design/lpht_hash.sv
design/linear_probe_hash_table_unit.sv
tb/tb_linear_probe_hash_table_unit.sv
